>>> rtl/pfdoc_pkg.sv
package pfdoc_pkg;

  localparam int FracBits    = 16;
  localparam int CordicSteps = 16;
  localparam int PayloadLen  = 24;
  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;
  localparam logic signed [40:0] HalfQ24 = 41'sd180 <<< 24;
  localparam logic signed [40:0] QuarterQ24 = 41'sd90 <<< 24;
  localparam logic signed [24:0] AngleLim = 25'sd11796480;

  localparam logic [0:0] RegOffX = 1'b0;
  localparam logic [0:0] RegOffY = 1'b1;

  function automatic logic [31:0] atan_q24(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd754974720;
      5'd1:  r = 32'd445687602;
      5'd2:  r = 32'd235489089;
      5'd3:  r = 32'd119537938;
      5'd4:  r = 32'd60000934;
      5'd5:  r = 32'd30029717;
      5'd6:  r = 32'd15018523;
      5'd7:  r = 32'd7509720;
      5'd8:  r = 32'd3754917;
      5'd9:  r = 32'd1877466;
      5'd10: r = 32'd938734;
      5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;
      5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;
      5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;
      5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;
      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;
      5'd21: r = 32'd458;
      5'd22: r = 32'd229;
      5'd23: r = 32'd115;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'h7fffffff;
    if (v < -35'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // IEEE single to signed fixed point, truncating, saturating
  function automatic logic signed [31:0] f2fix(input logic [31:0] b);
    logic [7:0] e;
    logic [23:0] sig;
    logic [40:0] mag;
    logic signed [9:0] sh;
    logic signed [31:0] r;
    e = b[30:23];
    sig = {1'b1, b[22:0]};
    sh = $signed({2'b00, e}) - 10'sd150 + 10'(FracBits);
    mag = '0;
    if (e == 8'hff) mag = (b[22:0] != 0) ? 41'd0 : (41'd1 << 40);
    else if (e == 8'd0) mag = '0;
    else if (sh < -10'sd24) mag = '0;
    else if (sh < 0) mag = 41'(sig >> 5'(-sh));
    else if (sh <= 10'sd8) mag = 41'(sig) << 4'(sh);
    else mag = 41'd1 << 40;
    if (e == 8'hff && b[22:0] != 0) r = '0;
    else if (!b[31]) r = (mag > 41'h7fffffff) ? 32'h7fffffff : mag[31:0];
    else r = (mag > 41'h80000000) ? 32'h80000000 : -(mag[31:0]);
    return r;
  endfunction

  function automatic logic signed [24:0] clamp_ang(input logic signed [31:0] v);
    if (v > 32'(AngleLim)) return AngleLim;
    if (v < -32'(AngleLim)) return -AngleLim;
    return v[24:0];
  endfunction

endpackage

>>> rtl/pose_frame_deframer_offset_correct_top.sv
// Result path: a closing CR leads through S_CONV, the yaw fold step, the CORDIC
// iterations, the multiply steps and S_FIN to S_OUT; a fold past +-90 degrees adds a negation step.
// Throughput: payload and framing bytes are taken one a cycle; a closing CR
// holds in_stall for the CORDIC iterations (one shared add/shift step a cycle)
// and the four shared-multiplier product steps, then until the result is taken.
// Reset (rst_n low, synchronous) clears parser, position state and offsets.
module pose_frame_deframer_offset_correct_top import pfdoc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_rx_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [24:0] out_yaw_angle,
  output logic signed [24:0] out_tilt_x_angle,
  output logic signed [24:0] out_tilt_y_angle,
  output logic signed [31:0] out_sensor_x,
  output logic signed [31:0] out_sensor_y,
  output logic signed [31:0] out_yaw_rate,
  output logic signed [31:0] out_delta_x,
  output logic signed [31:0] out_delta_y,
  output logic signed [31:0] out_chassis_x,
  output logic signed [31:0] out_chassis_y,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);

  typedef enum logic [2:0] {
    S_PARSE, S_CONV, S_ROT, S_MUL, S_FIN, S_OUT
  } state_t;
  typedef enum logic [2:0] {
    P_SEEK, P_CR, P_DATA, P_LF, P_TAIL
  } phase_t;

  state_t state_r;
  phase_t phase_r;
  logic [4:0] idx_r;
  logic [7:0] pay_r [PayloadLen];
  logic signed [26:0] offx_r, offy_r;
  logic signed [31:0] prevx_r, prevy_r, accx_r, accy_r;
  logic signed [40:0] z_r, cx_r, cy_r;
  logic [4:0] step_r;
  logic flip_r;
  logic [1:0] mstep_r;
  logic signed [63:0] prod_r, rx_r, ry_r;

  logic in_acc, cfg_wr;
  logic [31:0] w0, w1, w2, w3, w4, w5;
  logic signed [31:0] px, py;
  logic signed [31:0] dx, dy;
  logic signed [40:0] zin, sx, sy;
  logic signed [26:0] ma;
  logic signed [31:0] mb;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == RegOffY) ? 32'(offy_r) : 32'(offx_r);
  assign in_stall = (state_r != S_PARSE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);

  assign w0 = {pay_r[3], pay_r[2], pay_r[1], pay_r[0]};
  assign w1 = {pay_r[7], pay_r[6], pay_r[5], pay_r[4]};
  assign w2 = {pay_r[11], pay_r[10], pay_r[9], pay_r[8]};
  assign w3 = {pay_r[15], pay_r[14], pay_r[13], pay_r[12]};
  assign w4 = {pay_r[19], pay_r[18], pay_r[17], pay_r[16]};
  assign w5 = {pay_r[23], pay_r[22], pay_r[21], pay_r[20]};
  assign px = f2fix(w3);
  assign py = f2fix(w4);
  assign dx = sat32(35'(px) - 35'(prevx_r));
  assign dy = sat32(35'(py) - 35'(prevy_r));
  assign zin = 41'(out_yaw_angle) <<< (24 - FracBits);
  assign sx = cy_r >>> step_r;
  assign sy = cx_r >>> step_r;

  // shared multiplier: ox*c, oy*s, ox*s, oy*c; sin and cos stay within 32 bits
  always_comb begin
    case (mstep_r)
      2'd0: begin ma = offx_r; mb = cx_r[31:0]; end
      2'd1: begin ma = offy_r; mb = cy_r[31:0]; end
      2'd2: begin ma = offx_r; mb = cy_r[31:0]; end
      default: begin ma = offy_r; mb = cx_r[31:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_PARSE;
      phase_r <= P_SEEK;
      idx_r <= '0;
      offx_r <= '0;
      offy_r <= '0;
      prevx_r <= '0;
      prevy_r <= '0;
      accx_r <= '0;
      accy_r <= '0;
      prod_r <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == RegOffY) offy_r <= cfg_pwdata[26:0];
        else offx_r <= cfg_pwdata[26:0];
      end
      case (state_r)
        S_PARSE: if (in_acc) begin
          case (phase_r)
            P_SEEK: phase_r <= (in_rx_byte == CharCr) ? P_CR : P_SEEK;
            P_CR: begin
              if (in_rx_byte == CharLf) begin
                idx_r <= '0;
                phase_r <= P_DATA;
              end else if (in_rx_byte != CharCr) phase_r <= P_SEEK;
            end
            P_DATA: begin
              pay_r[idx_r] <= in_rx_byte;
              if (idx_r == 5'(PayloadLen - 1)) begin
                idx_r <= '0;
                phase_r <= P_LF;
              end else idx_r <= idx_r + 5'd1;
            end
            P_LF: phase_r <= (in_rx_byte == CharLf) ? P_TAIL : P_SEEK;
            P_TAIL: begin
              phase_r <= P_SEEK;
              if (in_rx_byte == CharCr) state_r <= S_CONV;
            end
            default: phase_r <= P_SEEK;
          endcase
        end
        S_CONV: begin
          out_yaw_angle <= clamp_ang(f2fix(w0));
          out_tilt_x_angle <= clamp_ang(f2fix(w1));
          out_tilt_y_angle <= clamp_ang(f2fix(w2));
          out_sensor_x <= px;
          out_sensor_y <= py;
          out_yaw_rate <= f2fix(w5);
          out_delta_x <= dx;
          out_delta_y <= dy;
          prevx_r <= px;
          prevy_r <= py;
          accx_r <= sat32(35'(accx_r) + 35'(dx));
          accy_r <= sat32(35'(accy_r) + 35'(dy));
          state_r <= S_ROT;
          // step 31 marks the fold cycle ahead of the iterations
          step_r <= 5'd31;
          flip_r <= 1'b0;
          cx_r <= 41'sd652032874;
          cy_r <= '0;
          z_r <= '0;
          mstep_r <= 2'd0;
        end
        S_ROT: begin
          if (step_r == 5'd31) begin
            // fold yaw into +-90 degrees once before iterating
            if (zin > QuarterQ24) begin z_r <= zin - HalfQ24; flip_r <= 1'b1; end
            else if (zin < -QuarterQ24) begin z_r <= zin + HalfQ24; flip_r <= 1'b1; end
            else z_r <= zin;
            step_r <= 5'd0;
          end else begin
            if (!z_r[40]) begin
              cx_r <= cx_r - sx;
              cy_r <= cy_r + sy;
              z_r <= z_r - 41'($signed({1'b0, atan_q24(step_r)}));
            end else begin
              cx_r <= cx_r + sx;
              cy_r <= cy_r - sy;
              z_r <= z_r + 41'($signed({1'b0, atan_q24(step_r)}));
            end
            if (step_r == 5'(CordicSteps - 1)) state_r <= S_MUL;
            else step_r <= step_r + 5'd1;
          end
        end
        S_MUL: begin
          if (flip_r && mstep_r == 2'd0 && prod_r != 64'sd1) begin
            cx_r <= -cx_r;
            cy_r <= -cy_r;
            prod_r <= 64'sd1;
          end else begin
            prod_r <= 64'(ma) * 64'(mb);
            case (mstep_r)
              2'd0: ;
              2'd1: rx_r <= prod_r;
              2'd2: rx_r <= rx_r - prod_r;
              default: ry_r <= prod_r;
            endcase
            mstep_r <= mstep_r + 2'd1;
            if (mstep_r == 2'd3) state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_chassis_x <= sat32(35'(accx_r) - 35'(rx_r >>> 30) + 35'(offx_r));
          out_chassis_y <= sat32(35'(accy_r) - 35'((ry_r + prod_r) >>> 30)
                                 + 35'(offy_r));
          prod_r <= '0;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_PARSE;
        default: state_r <= S_PARSE;
      endcase
    end
  end

endmodule

>>> dv/pfdoc_checker.sv
module pfdoc_checker import pfdoc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic out_valid,
  input  logic out_stall,
  input  logic signed [24:0] out_yaw_angle,
  input  logic signed [24:0] out_tilt_x_angle,
  input  logic signed [24:0] out_tilt_y_angle,
  input  logic signed [31:0] out_sensor_x,
  input  logic signed [31:0] out_sensor_y,
  input  logic signed [31:0] out_yaw_rate,
  input  logic signed [31:0] out_delta_x,
  input  logic signed [31:0] out_delta_y,
  input  logic signed [31:0] out_chassis_x,
  input  logic signed [31:0] out_chassis_y,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic cfg_pready,
  output int errors,
  output int pending,
  output int frames
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SEEK_CR, SEEK_LF, IN_PAYLOAD, TRAIL_LF, TRAIL_CR
  } parse_t;

  typedef struct packed {
    logic signed [24:0] yaw;
    logic signed [24:0] tilt_x;
    logic signed [24:0] tilt_y;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] rate;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } pose_t;

  parse_t phase;
  int unsigned idx;
  logic [7:0] payload [PayloadLen];
  longint last_x, last_y, sum_x, sum_y, off_x, off_y;
  pose_t pose_q[$];

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_angle(input longint v);
    longint lim;
    lim = longint'(180) <<< FracBits;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // single precision to Q16.16, truncating; NaN and subnormals read as zero
  function automatic longint single_to_q16(input logic [31:0] w);
    int ex, sh;
    longint unsigned sig, mag;
    ex = int'(w[30:23]);
    sig = {40'd1, w[22:0]};
    sh = ex - 150 + FracBits;
    if (ex == 255) begin
      if (w[22:0] != 0) return 0;
      mag = 64'd1 << 40;
    end else if (ex == 0) begin
      return 0;
    end else if (sh < -24) begin
      mag = 0;
    end else if (sh < 0) begin
      mag = sig >> (-sh);
    end else if (sh <= 8) begin
      mag = sig << sh;
    end else begin
      mag = 64'd1 << 40;
    end
    if (!w[31]) return (mag > 64'h7fffffff) ? 64'sd2147483647 : longint'(mag);
    return (mag > 64'h80000000) ? -64'sd2147483648 : -longint'(mag);
  endfunction

  function automatic logic [31:0] word_at(input int k);
    return {payload[4*k+3], payload[4*k+2], payload[4*k+1], payload[4*k]};
  endfunction

  task automatic predict_pose();
    pose_t p;
    longint yaw, px, py, ddx, ddy, z, cx, sy, tx, ty, rx, ry;
    bit flip;
    yaw = clip_angle(single_to_q16(word_at(0)));
    px = single_to_q16(word_at(3));
    py = single_to_q16(word_at(4));
    ddx = clip32(px - last_x);
    ddy = clip32(py - last_y);
    last_x = px;
    last_y = py;
    sum_x = clip32(sum_x + ddx);
    sum_y = clip32(sum_y + ddy);
    // fold yaw into +-90 deg, rotate, then undo the fold by negating
    z = yaw <<< (24 - FracBits);
    flip = 0;
    if (z > (longint'(90) <<< 24)) begin
      z -= longint'(180) <<< 24;
      flip = 1;
    end else if (z < -(longint'(90) <<< 24)) begin
      z += longint'(180) <<< 24;
      flip = 1;
    end
    cx = 652032874;
    sy = 0;
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      tx = sy >>> i;
      ty = cx >>> i;
      if (z >= 0) begin
        cx -= tx; sy += ty; z -= longint'(atan_q24(5'(i)));
      end else begin
        cx += tx; sy -= ty; z += longint'(atan_q24(5'(i)));
      end
    end
    if (flip) begin
      cx = -cx; sy = -sy;
    end
    rx = (off_x * cx - off_y * sy) >>> 30;
    ry = (off_x * sy + off_y * cx) >>> 30;
    p.yaw = 25'(yaw);
    p.tilt_x = 25'(clip_angle(single_to_q16(word_at(1))));
    p.tilt_y = 25'(clip_angle(single_to_q16(word_at(2))));
    p.sx = 32'(px);
    p.sy = 32'(py);
    p.rate = 32'(single_to_q16(word_at(5)));
    p.dx = 32'(ddx);
    p.dy = 32'(ddy);
    p.cx = 32'(clip32(sum_x - rx + off_x));
    p.cy = 32'(clip32(sum_y - ry + off_y));
    pose_q.push_back(p);
  endtask

  task automatic take_byte(input logic [7:0] b);
    case (phase)
      SEEK_CR: phase = (b == CharCr) ? SEEK_LF : SEEK_CR;
      SEEK_LF: begin
        if (b == CharLf) begin
          idx = 0;
          phase = IN_PAYLOAD;
        end else if (b != CharCr) begin
          phase = SEEK_CR;
        end
      end
      IN_PAYLOAD: begin
        payload[idx] = b;
        idx++;
        if (idx >= PayloadLen) begin
          idx = 0;
          phase = TRAIL_LF;
        end
      end
      TRAIL_LF: phase = (b == CharLf) ? TRAIL_CR : SEEK_CR;
      TRAIL_CR: begin
        phase = SEEK_CR;
        if (b == CharCr) predict_pose();
      end
      default: phase = SEEK_CR;
    endcase
  endtask

  task automatic check_pose();
    pose_t got, want;
    got = '{out_yaw_angle, out_tilt_x_angle, out_tilt_y_angle, out_sensor_x, out_sensor_y,
            out_yaw_rate, out_delta_x, out_delta_y, out_chassis_x, out_chassis_y};
    frames++;
    if (pose_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transfer: %p", got);
      return;
    end
    want = pose_q.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("pose mismatch\n  exp %p\n  got %p", want, got);
    end
  endtask

  initial begin
    errors = 0;
    frames = 0;
  end

  assign pending = pose_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = SEEK_CR;
      idx = 0;
      last_x = 0; last_y = 0; sum_x = 0; sum_y = 0;
      off_x = 0; off_y = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == RegOffX) off_x = longint'($signed(cfg_pwdata[26:0]));
        else off_y = longint'($signed(cfg_pwdata[26:0]));
      end
      if (in_valid && !in_stall) take_byte(in_rx_byte);
      if (out_valid && !out_stall) check_pose();
    end
  end
endmodule

>>> dv/tb.sv
module tb import pfdoc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FlawNone = 0;
  localparam int FlawExtraCr = 1;
  localparam int FlawBadLf = 2;
  localparam int FlawBadCr = 3;
  localparam int FlawHeader = 4;
  localparam int StallLimit = 4000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] in_rx_byte = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [24:0] out_yaw_angle, out_tilt_x_angle, out_tilt_y_angle;
  logic signed [31:0] out_sensor_x, out_sensor_y, out_yaw_rate;
  logic signed [31:0] out_delta_x, out_delta_y, out_chassis_x, out_chassis_y;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  int errors, pending, frames;
  int send_idle = 0, recv_stall = 0;
  int bytes_sent = 0, settings = 0;
  int quiet = 0;
  logic hold_rx = 0;
  bit pressure_go = 0;

  pose_frame_deframer_offset_correct_top dut (.*);

  pfdoc_checker chk (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= hold_rx || ($urandom_range(99) < recv_stall);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1;
    repeat (400) @(posedge clk);
    hold_rx <= 0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("[pose_frame_deframer_offset_correct_top] ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic write_offset(input logic [0:0] reg_id, input int value);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {reg_id, 2'b00};
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  task automatic send_frame(input logic [31:0] w [6], input int flaw);
    send_byte(CharCr);
    if (flaw == FlawExtraCr) repeat ($urandom_range(3, 1)) send_byte(CharCr);
    if (flaw == FlawHeader) begin
      send_byte(8'($urandom_range(255)));
      return;
    end
    send_byte(CharLf);
    for (int i = 0; i < 24; i++) send_byte(w[i / 4][8 * (i % 4) +: 8]);
    send_byte(flaw == FlawBadLf ? CharCr : CharLf);
    send_byte(flaw == FlawBadCr ? CharLf : CharCr);
  endtask

  function automatic logic [31:0] rand_single(input bit angle);
    int k;
    logic s;
    k = $urandom_range(99);
    s = 1'($urandom);
    if (k < 5) return {s, 8'hff, 23'($urandom_range(32'h7fffff, 1))};
    if (k < 8) return {s, 8'hff, 23'd0};
    if (k < 11) return {s, 8'h00, 23'($urandom)};
    if (k < 16) return $urandom;
    if (k < 20) return {s, 8'($urandom_range(200, 143)), 23'($urandom)};
    if (angle) return {s, 8'($urandom_range(134, 110)), 23'($urandom)};
    return {s, 8'($urandom_range(145, 100)), 23'($urandom)};
  endfunction

  task automatic random_burst(input int min_bytes, input int min_frames);
    logic [31:0] w [6];
    int start_b, start_f, k;
    start_b = bytes_sent;
    start_f = frames + pending;
    while (bytes_sent - start_b < min_bytes || frames + pending - start_f < min_frames) begin
      k = $urandom_range(99);
      if (k < 75) begin
        for (int j = 0; j < 6; j++) w[j] = rand_single(j < 3);
        k = $urandom_range(99);
        send_frame(w, k < 70 ? FlawNone : k < 80 ? FlawExtraCr : k < 87 ? FlawBadLf :
                      k < 94 ? FlawBadCr : FlawHeader);
      end else begin
        repeat ($urandom_range(5, 1)) begin
          k = $urandom_range(9);
          send_byte(k == 0 ? CharCr : k == 1 ? CharLf : 8'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    logic [31:0] w [6];
    int ox [4], oy [4];
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: plain values, right-angle and half-turn yaws, specials, flaws
    w = '{32'h42b40000, 32'h00000000, 32'h80000000, 32'h3f800000, 32'hbf800000, 32'h0};
    send_frame(w, FlawNone);
    w = '{32'h43340000, 32'h7f800000, 32'hff800000, 32'h7f7fffff, 32'hff7fffff, 32'h7fc00001};
    send_frame(w, FlawExtraCr);
    w = '{32'hc3340000, 32'h00000001, 32'h807fffff, 32'h46fffffe, 32'hc7000000, 32'h33800000};
    send_frame(w, FlawNone);
    w = '{32'hc2b40000, 32'hffffffff, 32'h43480000, 32'h4f000000, 32'hcf000000, 32'h37800000};
    send_frame(w, FlawBadCr);
    send_frame(w, FlawBadLf);
    send_frame(w, FlawHeader);
    w = '{32'h43480000, 32'hc3480000, 32'h42b40001, 32'hcf000000, 32'h4f000000, 32'h46000000};
    send_frame(w, FlawNone);
    send_byte(8'hff);
    send_byte(8'h00);

    ox = '{65536000, -65536000, 0, 0};
    oy = '{-65536000, 65536000, 0, 0};
    ox[2] = $urandom_range(131072000) - 65536000;
    oy[2] = $urandom_range(131072000) - 65536000;
    ox[3] = 65536000;
    oy[3] = 65536000;
    for (int ph = 0; ph < 4; ph++) begin
      write_offset(RegOffX, ox[ph]);
      write_offset(RegOffY, oy[ph]);
      settings++;
      send_idle = (ph == 1) ? 81 : (ph == 3) ? 7 : 0;
      recv_stall = (ph == 2) ? 81 : (ph == 3) ? 7 : 0;
      if (ph == 0) pressure_go = 1;
      random_burst(200, 4);
      send_idle = 0;
      recv_stall = 0;
      random_burst(20, 0);
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("run covered %0d bytes, %0d poses, %0d offset settings, all idle mixes",
             bytes_sent, frames, settings);
    if (errors == 0) begin
      $display("[pose_frame_deframer_offset_correct_top] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[pose_frame_deframer_offset_correct_top] ERROR");
    end
    $finish;
  end
endmodule
